@@ src/tt_pkg.sv @@
`default_nettype none

package tt_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int TABLE_DEPTH = 1 << INDEX_BITS;
	localparam int KEY_W       = 64;
	localparam int TAG_W       = KEY_W - INDEX_BITS;

	// scores of this magnitude or more are mate-range and never stored
	localparam logic signed [20:0] MATE_POS = 21'sd99000;
	localparam logic signed [20:0] MATE_NEG = -21'sd99000;

	typedef enum logic [1:0] {
		ACT_PROBE = 2'd0,
		ACT_STORE = 2'd1,
		ACT_CLEAR = 2'd2
	} tt_action_t;

	typedef enum logic [1:0] {
		BOUND_EXACT = 2'd0,
		BOUND_LOWER = 2'd1,
		BOUND_UPPER = 2'd2
	} tt_bound_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} tt_state_t;

	// only the key bits above the index are kept; blank marks an entry that
	// still holds the all-zero key from a clear
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic               blank;
		logic signed [7:0]  depth;
		logic signed [17:0] score;
		logic [1:0]         bound;
		logic signed [6:0]  from;
		logic [5:0]         to;
		logic [7:0]         promo;
		logic               ep;
	} tt_entry_t;

	localparam tt_entry_t RESET_ENTRY = '{
		tag:   '0,
		blank: 1'b1,
		depth: -8'sd1,
		score: '0,
		bound: BOUND_EXACT,
		from:  -7'sd1,
		to:    '0,
		promo: '0,
		ep:    1'b0
	};

	typedef struct packed {
		logic rd_en;
		logic load;
		logic clr_wr;
	} tt_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic clr_last;
	} tt_stat_t;

endpackage

`default_nettype wire

@@ src/tt_ram.sv @@
`default_nettype none

module tt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ src/tt_ctrl.sv @@
`default_nettype none

module tt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire tt_pkg::tt_stat_t  stat,
	output tt_pkg::tt_cmd_t        cmd
);
	import tt_pkg::*;

	tt_state_t state_q, state_d;
	logic      out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold here while the previous result is still unclaimed
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = stat.is_clear ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		out_valid_d = cmd.load | (out_valid_q & ~out_ready);
	end

	assign out_valid = out_valid_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted transaction not followed by execute");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an unclaimed result");

	a_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("result dropped without transaction");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !out_ready) |=> (state_q == ST_EXEC))
		else $error("execute left while output stalled");

endmodule

`default_nettype wire

@@ src/tt_dp.sv @@
`default_nettype none

module tt_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tt_pkg::tt_cmd_t    cmd,
	output tt_pkg::tt_stat_t        stat,
	input  wire logic [1:0]         action,
	input  wire logic [63:0]        key,
	input  wire logic [6:0]         depth,
	input  wire logic signed [20:0] alpha,
	input  wire logic signed [20:0] beta,
	input  wire logic signed [20:0] score,
	input  wire logic signed [6:0]  move_from,
	input  wire logic [5:0]         move_to,
	input  wire logic [7:0]         move_promotion,
	input  wire logic               move_en_passant,
	output logic                    hit,
	output logic                    cutoff,
	output logic signed [17:0]      entry_score,
	output logic signed [6:0]       hint_from,
	output logic [5:0]              hint_to,
	output logic [7:0]              hint_promotion,
	output logic                    hint_en_passant,
	output logic                    written
);
	import tt_pkg::*;

	logic [1:0]         action_q;
	logic [63:0]        key_q;
	logic [6:0]         depth_q;
	logic signed [20:0] alpha_q, beta_q, score_q;
	logic signed [6:0]  from_q;
	logic [5:0]         to_q;
	logic [7:0]         promo_q;
	logic               ep_q;

	logic [INDEX_BITS-1:0] clr_cnt_q;

	tt_entry_t             rd_entry, new_entry;
	logic [$bits(tt_entry_t)-1:0] rd_word, wr_word;
	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_addr;

	logic               tag_hit, depth_ok, cut_d, mag_ok, replace, store_d;
	logic signed [20:0] ext_score;
	logic signed [7:0]  new_depth;
	tt_bound_t          new_bound;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			action_q <= action;
			key_q    <= key;
			depth_q  <= depth;
			alpha_q  <= alpha;
			beta_q   <= beta;
			score_q  <= score;
			from_q   <= move_from;
			to_q     <= move_to;
			promo_q  <= move_promotion;
			ep_q     <= move_en_passant;
		end
	end

	// sweep counter rests at zero and wraps back there after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign stat.clr_last = &clr_cnt_q;
	assign stat.is_clear = (action_q == ACT_CLEAR);

	tt_ram #(
		.WIDTH($bits(tt_entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_word),
		.rd_en  (cmd.rd_en),
		.rd_addr(key[INDEX_BITS-1:0]),
		.rd_data(rd_word)
	);

	assign rd_entry = tt_entry_t'(rd_word);

	always_comb begin
		// a blank entry holds the full key zero, so only key zero matches it
		tag_hit   = rd_entry.blank ? (key_q == '0)
			: (rd_entry.tag == key_q[KEY_W-1:INDEX_BITS]);
		ext_score = {{3{rd_entry.score[17]}}, rd_entry.score};
		new_depth = $signed({1'b0, depth_q});
		depth_ok  = (rd_entry.depth >= new_depth);
		case (rd_entry.bound)
			BOUND_EXACT: cut_d = depth_ok;
			BOUND_LOWER: cut_d = depth_ok && (ext_score >= beta_q);
			BOUND_UPPER: cut_d = depth_ok && (ext_score <= alpha_q);
			default:     cut_d = 1'b0;
		endcase

		mag_ok = (score_q > MATE_NEG) && (score_q < MATE_POS);
		if (score_q <= alpha_q) begin
			new_bound = BOUND_UPPER;
		end else if (score_q >= beta_q) begin
			new_bound = BOUND_LOWER;
		end else begin
			new_bound = BOUND_EXACT;
		end
		replace = !tag_hit || (new_depth >= rd_entry.depth);
		store_d = (action_q == ACT_STORE) && mag_ok && replace;

		new_entry.tag   = key_q[KEY_W-1:INDEX_BITS];
		new_entry.blank = 1'b0;
		new_entry.depth = new_depth;
		new_entry.score = score_q[17:0];
		new_entry.bound = new_bound;
		new_entry.from  = from_q;
		new_entry.to    = to_q;
		new_entry.promo = promo_q;
		new_entry.ep    = ep_q;

		wr_en   = cmd.clr_wr | (cmd.load & store_d);
		wr_addr = cmd.clr_wr ? clr_cnt_q : key_q[INDEX_BITS-1:0];
		wr_word = cmd.clr_wr ? RESET_ENTRY : new_entry;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if ((action_q == ACT_PROBE) && tag_hit) begin
				hit             <= 1'b1;
				cutoff          <= cut_d;
				entry_score     <= rd_entry.score;
				hint_from       <= rd_entry.from;
				hint_to         <= rd_entry.to;
				hint_promotion  <= rd_entry.promo;
				hint_en_passant <= rd_entry.ep;
			end else begin
				hit             <= 1'b0;
				cutoff          <= 1'b0;
				entry_score     <= '0;
				hint_from       <= -7'sd1;
				hint_to         <= '0;
				hint_promotion  <= '0;
				hint_en_passant <= 1'b0;
			end
			written <= store_d;
		end
	end

endmodule

`default_nettype wire

@@ src/transposition_table_core.sv @@
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_ready   action key depth alpha beta score move_*
// output    out_valid / out_ready hit cutoff entry_score hint_* written
//
// Probe and store: the accepting edge reads the table RAM, the execute state
// evaluates the entry, writes it back on a store and loads the result.
// Clear loads its result, then the sweep writes one entry per cycle.
// After reset the same sweep runs with in_ready low.
// A result waits in the output register; the next transaction is accepted
// meanwhile, and evaluation stalls only when a second result would overwrite it.

module transposition_table_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic [63:0]        key,
	input  wire logic [6:0]         depth,
	input  wire logic signed [20:0] alpha,
	input  wire logic signed [20:0] beta,
	input  wire logic signed [20:0] score,
	input  wire logic signed [6:0]  move_from,
	input  wire logic [5:0]         move_to,
	input  wire logic [7:0]         move_promotion,
	input  wire logic               move_en_passant,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic                    cutoff,
	output logic signed [17:0]      entry_score,
	output logic signed [6:0]       hint_from,
	output logic [5:0]              hint_to,
	output logic [7:0]              hint_promotion,
	output logic                    hint_en_passant,
	output logic                    written
);
	import tt_pkg::*;

	tt_cmd_t  cmd;
	tt_stat_t stat;

	tt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.key            (key),
		.depth          (depth),
		.alpha          (alpha),
		.beta           (beta),
		.score          (score),
		.move_from      (move_from),
		.move_to        (move_to),
		.move_promotion (move_promotion),
		.move_en_passant(move_en_passant),
		.hit            (hit),
		.cutoff         (cutoff),
		.entry_score    (entry_score),
		.hint_from      (hint_from),
		.hint_to        (hint_to),
		.hint_promotion (hint_promotion),
		.hint_en_passant(hint_en_passant),
		.written        (written)
	);

endmodule

`default_nettype wire
